[hw/rtl/arpudp_pkg.sv]
// Shared types, constants and reply-frame builder for the ARP responder / UDP filter.
package arpudp_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);

  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OUR_MAC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_MAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUR_IP     = 2'd2;

  localparam logic [MAC_W-1:0] OUR_MAC_RST    = 48'h000958D81122;
  localparam logic [MAC_W-1:0] SERVER_MAC_RST = 48'h00142AA55097;
  localparam logic [IP_W-1:0]  OUR_IP_RST     = 32'hC0A801FC;

  localparam logic [15:0] ETH_ARP      = 16'h0806;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] ARP_HW_ETH   = 16'h0001;
  localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
  localparam logic [7:0]  ARP_HLEN     = 8'h06;
  localparam logic [7:0]  ARP_PLEN     = 8'h04;
  localparam logic [7:0]  IP_UDP       = 8'd17;
  localparam logic [3:0]  IHL_NO_OPTS  = 4'd5;
  localparam logic [7:0]  IHL_MASK     = 8'h0F;

  localparam logic KIND_UDP = 1'b0;
  localparam logic KIND_ARP = 1'b1;

  localparam int REPLY_LEN = 42;
  localparam int REPLY_W   = $clog2(REPLY_LEN);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [REPLY_W-1:0] ridx_t;

  // one queued request: a forwarded payload byte or a whole ARP reply
  typedef struct packed {
    logic              is_arp;
    logic [7:0]        data;
    logic [PORT_W-1:0] sport;
    logic              last;
    logic [MAC_W-1:0]  req_mac;
    logic [IP_W-1:0]   req_ip;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] arp_reply_byte(
    input ridx_t            idx,
    input logic [MAC_W-1:0] srv_mac,
    input logic [MAC_W-1:0] own_mac,
    input logic [IP_W-1:0]  own_ip,
    input logic [MAC_W-1:0] req_mac,
    input logic [IP_W-1:0]  req_ip
  );
    logic [REPLY_LEN-1:0][7:0] frame;
    ridx_t                     sel;
    frame = {srv_mac, own_mac, ETH_ARP, ARP_HW_ETH, ETH_IPV4, ARP_HLEN, ARP_PLEN,
             ARP_OP_REPLY, own_mac, own_ip, req_mac, req_ip};
    // byte 0 sits in the top lane
    sel = ridx_t'(REPLY_LEN - 1) - idx;
    return frame[sel];
  endfunction

endpackage

[hw/rtl/arpudp_if.sv]
// Byte-stream interfaces for the received frame and the result channel.
interface arpudp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface arpudp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [15:0] udp_source_port;
  logic        run_last;

  modport source (output valid, kind, out_byte, udp_source_port, run_last, input ready);
  modport sink   (input valid, kind, out_byte, udp_source_port, run_last, output ready);
endinterface

[hw/rtl/arpudp_parser.sv]
// Front end: tracks byte position, captures header fields and classifies each byte.
module arpudp_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [7:0]                      rx_byte,
  input  logic                            frame_end,
  input  logic [arpudp_pkg::IP_W-1:0]     our_ip,
  output logic                            push,
  output arpudp_pkg::cmd_t                cmd
);
  import arpudp_pkg::*;

  pos_t              pos_r, pos_nxt;
  logic [15:0]       ftype_r, ftype_nxt;
  logic [15:0]       op_r, op_nxt;
  logic [MAC_W-1:0]  req_mac_r, req_mac_nxt;
  logic [IP_W-1:0]   req_ip_r, req_ip_nxt;
  logic [IP_W-1:0]   tgt_ip_r, tgt_ip_nxt;
  logic [3:0]        ihl_r, ihl_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [IP_W-1:0]   dst_ip_r, dst_ip_nxt;
  logic [PORT_W-1:0] sport_r, sport_nxt;
  logic              arp_hit, udp_hit;

  localparam pos_t POS_MAX = pos_t'(MAX_FRAME_BYTES - 1);

  always_comb begin
    ftype_nxt   = ftype_r;
    op_nxt      = op_r;
    req_mac_nxt = req_mac_r;
    req_ip_nxt  = req_ip_r;
    tgt_ip_nxt  = tgt_ip_r;
    ihl_nxt     = ihl_r;
    proto_nxt   = proto_r;
    dst_ip_nxt  = dst_ip_r;
    sport_nxt   = sport_r;
    pos_nxt     = pos_r;
    if (accept) begin
      if (pos_r == pos_t'(12) || pos_r == pos_t'(13)) ftype_nxt = {ftype_r[7:0], rx_byte};
      if (pos_r == pos_t'(20) || pos_r == pos_t'(21)) op_nxt = {op_r[7:0], rx_byte};
      if (pos_r >= pos_t'(22) && pos_r <= pos_t'(27))
        req_mac_nxt = {req_mac_r[MAC_W-9:0], rx_byte};
      if (pos_r >= pos_t'(28) && pos_r <= pos_t'(31))
        req_ip_nxt = {req_ip_r[IP_W-9:0], rx_byte};
      if (pos_r >= pos_t'(38) && pos_r <= pos_t'(41))
        tgt_ip_nxt = {tgt_ip_r[IP_W-9:0], rx_byte};
      if (pos_r == pos_t'(14)) ihl_nxt = 4'(rx_byte & IHL_MASK);
      if (pos_r == pos_t'(23)) proto_nxt = rx_byte;
      if (pos_r >= pos_t'(30) && pos_r <= pos_t'(33))
        dst_ip_nxt = {dst_ip_r[IP_W-9:0], rx_byte};
      if (pos_r == pos_t'(34) || pos_r == pos_t'(35)) sport_nxt = {sport_r[7:0], rx_byte};
      // restart on frame end, hold at the top for oversize frames
      if (frame_end)
        pos_nxt = '0;
      else if (pos_r != POS_MAX)
        pos_nxt = pos_r + pos_t'(1);
    end
  end

  assign arp_hit = accept && pos_r == pos_t'(41) && ftype_r == ETH_ARP &&
                   op_r == ARP_OP_REQ && tgt_ip_nxt == our_ip;
  assign udp_hit = accept && pos_r >= pos_t'(42) && ftype_r == ETH_IPV4 &&
                   ihl_r == IHL_NO_OPTS && dst_ip_r == our_ip && proto_r == IP_UDP;

  assign push        = arp_hit || udp_hit;
  assign cmd.is_arp  = arp_hit;
  assign cmd.data    = rx_byte;
  assign cmd.sport   = sport_r;
  assign cmd.last    = frame_end;
  assign cmd.req_mac = req_mac_r;
  assign cmd.req_ip  = req_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ftype_r   <= '0;
      op_r      <= '0;
      req_mac_r <= '0;
      req_ip_r  <= '0;
      tgt_ip_r  <= '0;
      ihl_r     <= '0;
      proto_r   <= '0;
      dst_ip_r  <= '0;
      sport_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      ftype_r   <= ftype_nxt;
      op_r      <= op_nxt;
      req_mac_r <= req_mac_nxt;
      req_ip_r  <= req_ip_nxt;
      tgt_ip_r  <= tgt_ip_nxt;
      ihl_r     <= ihl_nxt;
      proto_r   <= proto_nxt;
      dst_ip_r  <= dst_ip_nxt;
      sport_r   <= sport_nxt;
    end
  end

endmodule

[hw/rtl/arpudp_queue.sv]
// Short request queue between the classifier and the output sequencer.
module arpudp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  arpudp_pkg::cmd_t      push_cmd,
  input  logic                  pop,
  output arpudp_pkg::cmd_t      head,
  output arpudp_pkg::q_stat_t   stat
);
  import arpudp_pkg::*;

  cmd_t                 mem_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/arpudp_emitter.sv]
// Back end: turns queued requests into result bytes, expanding ARP replies to 42 bytes.
module arpudp_emitter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arpudp_pkg::cmd_t              head,
  input  logic                          head_valid,
  input  logic [arpudp_pkg::MAC_W-1:0]  our_mac,
  input  logic [arpudp_pkg::MAC_W-1:0]  server_mac,
  input  logic [arpudp_pkg::IP_W-1:0]   our_ip,
  input  logic                          out_ready,
  output logic                          pop,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [7:0]                    out_data,
  output logic [arpudp_pkg::PORT_W-1:0] out_sport,
  output logic                          out_last
);
  import arpudp_pkg::*;

  localparam ridx_t IDX_LAST = ridx_t'(REPLY_LEN - 1);

  ridx_t             idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic              kind_r, kind_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [PORT_W-1:0] sport_r, sport_nxt;
  logic              last_r, last_nxt;
  logic              load;

  assign load = head_valid && (!vld_r || out_ready);
  assign pop  = load && (!head.is_arp || idx_r == IDX_LAST);

  always_comb begin
    idx_nxt   = idx_r;
    vld_nxt   = vld_r && !out_ready;
    kind_nxt  = kind_r;
    data_nxt  = data_r;
    sport_nxt = sport_r;
    last_nxt  = last_r;
    if (load) begin
      vld_nxt = 1'b1;
      if (head.is_arp) begin
        kind_nxt  = KIND_ARP;
        data_nxt  = arp_reply_byte(idx_r, server_mac, our_mac, our_ip,
                                   head.req_mac, head.req_ip);
        sport_nxt = '0;
        last_nxt  = idx_r == IDX_LAST;
        idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + ridx_t'(1);
      end else begin
        kind_nxt  = KIND_UDP;
        data_nxt  = head.data;
        sport_nxt = head.sport;
        last_nxt  = head.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    data_r  <= data_nxt;
    sport_r <= sport_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid = vld_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_sport = sport_r;
  assign out_last  = last_r;

endmodule

[hw/rtl/arp_responder_udp_rx_filter_core.sv]
// ARP responder and IPv4/UDP receive filter top level.
// Input: one frame byte per cycle; ready drops only while the 4-entry request queue is full.
// Path: an accepted byte is written into the request queue, then registered at the output.
// Output: a byte per cycle while ready; an ARP reply holds one queue slot for its 42 bytes.
// Reset (rst_n low, synchronous): byte position, queue and output valid clear; the address
// registers load their default values.
module arp_responder_udp_rx_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  arpudp_in_if.sink                           in_ch,
  arpudp_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [arpudp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arpudp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import arpudp_pkg::*;

  logic [MAC_W-1:0] our_mac_r, our_mac_nxt;
  logic [MAC_W-1:0] server_mac_r, server_mac_nxt;
  logic [IP_W-1:0]  our_ip_r, our_ip_nxt;

  logic    accept;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  always_comb begin
    our_mac_nxt    = our_mac_r;
    server_mac_nxt = server_mac_r;
    our_ip_nxt     = our_ip_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_OUR_MAC:    our_mac_nxt    = cfg_wdata;
        REG_SERVER_MAC: server_mac_nxt = cfg_wdata;
        REG_OUR_IP:     our_ip_nxt     = cfg_wdata[IP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      our_mac_r    <= OUR_MAC_RST;
      server_mac_r <= SERVER_MAC_RST;
      our_ip_r     <= OUR_IP_RST;
    end else begin
      our_mac_r    <= our_mac_nxt;
      server_mac_r <= server_mac_nxt;
      our_ip_r     <= our_ip_nxt;
    end
  end

  // stall the byte stream only when no queue slot is free
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  arpudp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_ch.rx_byte),
    .frame_end (in_ch.frame_end),
    .our_ip    (our_ip_r),
    .push      (push),
    .cmd       (push_cmd)
  );

  arpudp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  arpudp_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_stat.empty),
    .our_mac    (our_mac_r),
    .server_mac (server_mac_r),
    .our_ip     (our_ip_r),
    .out_ready  (out_ch.ready),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_kind   (out_ch.kind),
    .out_data   (out_ch.out_byte),
    .out_sport  (out_ch.udp_source_port),
    .out_last   (out_ch.run_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("request popped from an empty queue");

  a_arp_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_ARP) |-> out_ch.udp_source_port == '0)
    else $error("reply byte carries a nonzero source port");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

[bench/arp_udp_rx_checker.sv]
`timescale 1ns / 100ps
// Checker for the ARP responder / UDP filter: predicts result bytes and compares them.
module arp_udp_rx_checker
  import arpudp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  arpudp_in_if                  in_ch,
  arpudp_out_if                 out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           owed_count
);

  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [PORT_W-1:0] sport;
    logic              last;
  } rx_result_t;

  rx_result_t due_bytes[$];

  logic [MAC_W-1:0]  own_mac;
  logic [MAC_W-1:0]  boot_mac;
  logic [IP_W-1:0]   own_ip;

  pos_t              pos;
  logic [15:0]       eth_type;
  logic [15:0]       arp_op;
  logic [MAC_W-1:0]  sender_mac;
  logic [IP_W-1:0]   sender_ip;
  logic [IP_W-1:0]   tgt_ip;
  logic [3:0]        ihl;
  logic [7:0]        proto;
  logic [IP_W-1:0]   dst_ip;
  logic [PORT_W-1:0] src_port;

  task automatic filter_rx_byte(input logic [7:0] b, input logic last);
    logic [REPLY_LEN*8-1:0] reply;
    rx_result_t             r;
    if (pos == 12 || pos == 13) eth_type = {eth_type[7:0], b};
    if (pos == 20 || pos == 21) arp_op = {arp_op[7:0], b};
    if (pos >= 22 && pos <= 27) sender_mac = {sender_mac[MAC_W-9:0], b};
    if (pos >= 28 && pos <= 31) sender_ip = {sender_ip[IP_W-9:0], b};
    if (pos >= 38 && pos <= 41) tgt_ip = {tgt_ip[IP_W-9:0], b};
    if (pos == 14) ihl = b[3:0];
    if (pos == 23) proto = b;
    if (pos >= 30 && pos <= 33) dst_ip = {dst_ip[IP_W-9:0], b};
    if (pos == 34 || pos == 35) src_port = {src_port[7:0], b};

    if (pos == 41 && eth_type == ETH_ARP && arp_op == ARP_OP_REQ && tgt_ip == own_ip) begin
      // the whole reply frame is queued as expected bytes at once, byte 0 first
      reply = {boot_mac, own_mac, ETH_ARP, ARP_HW_ETH, ETH_IPV4, ARP_HLEN, ARP_PLEN,
               ARP_OP_REPLY, own_mac, own_ip, sender_mac, sender_ip};
      for (int i = 0; i < REPLY_LEN; i++) begin
        r.kind  = KIND_ARP;
        r.data  = reply[(REPLY_LEN-1-i)*8 +: 8];
        r.sport = '0;
        r.last  = (i == REPLY_LEN - 1);
        due_bytes.push_back(r);
      end
    end else if (pos >= 42 && eth_type == ETH_IPV4 && ihl == IHL_NO_OPTS &&
                 dst_ip == own_ip && proto == IP_UDP) begin
      r.kind  = KIND_UDP;
      r.data  = b;
      r.sport = src_port;
      r.last  = last;
      due_bytes.push_back(r);
    end

    // restart the position on the last byte, saturate it on oversized frames
    if (last) begin
      pos = '0;
    end else if (pos < MAX_FRAME_BYTES - 1) begin
      pos = pos + 1'b1;
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : observe
    rx_result_t want;
    if (!rst_n) begin
      own_mac    = OUR_MAC_RST;
      boot_mac   = SERVER_MAC_RST;
      own_ip     = OUR_IP_RST;
      pos        = '0;
      eth_type   = '0;
      arp_op     = '0;
      sender_mac = '0;
      sender_ip  = '0;
      tgt_ip     = '0;
      ihl        = '0;
      proto      = '0;
      dst_ip     = '0;
      src_port   = '0;
      fail_count = 0;
      due_bytes.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_bytes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %b byte %h port %h last %b",
                   $time, out_ch.kind, out_ch.out_byte, out_ch.udp_source_port,
                   out_ch.run_last);
          fail_count++;
        end else begin
          want = due_bytes.pop_front();
          if (out_ch.kind !== want.kind)
            flag_mismatch("kind", 16'(want.kind), 16'(out_ch.kind));
          if (out_ch.out_byte !== want.data)
            flag_mismatch("out_byte", 16'(want.data), 16'(out_ch.out_byte));
          if (out_ch.udp_source_port !== want.sport)
            flag_mismatch("udp_source_port", want.sport, out_ch.udp_source_port);
          if (out_ch.run_last !== want.last)
            flag_mismatch("run_last", 16'(want.last), 16'(out_ch.run_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OUR_MAC:    own_mac = cfg_wdata[MAC_W-1:0];
          REG_SERVER_MAC: boot_mac = cfg_wdata[MAC_W-1:0];
          REG_OUR_IP:     own_ip = cfg_wdata[IP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) filter_rx_byte(in_ch.rx_byte, in_ch.frame_end);
    end
    owed_count = due_bytes.size();
  end

endmodule

[bench/arp_responder_udp_rx_filter_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top: frame stimulus, register writes, output stalls and the final verdict.
module arp_responder_udp_rx_filter_core_tb;
  import arpudp_pkg::*;

  localparam int DRAIN_CYCLES     = 8;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int FRAMES_PER_PHASE = 1;
  localparam int TIMEOUT_NS       = 20_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [3:0]  IP_VER4  = 4'd4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           owed_count;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  bit                    hold_off_req = 1'b0;
  logic [IP_W-1:0]       cur_our_ip = OUR_IP_RST;
  logic [7:0]            frame_bytes[$];

  arpudp_in_if  in_if();
  arpudp_out_if out_if();

  arp_responder_udp_rx_filter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  arp_udp_rx_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append n bytes of v, most significant first
  function automatic void put_field(input logic [47:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) frame_bytes.push_back(v[i*8 +: 8]);
  endfunction

  function automatic void set_length(input int len);
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
  endfunction

  function automatic void build_arp(input logic [15:0] op, input logic [IP_W-1:0] tpa,
                                    input int len);
    frame_bytes.delete();
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'(ETH_ARP), 2);
    put_field(48'(ARP_HW_ETH), 2);
    put_field(48'(ETH_IPV4), 2);
    frame_bytes.push_back(ARP_HLEN);
    frame_bytes.push_back(ARP_PLEN);
    put_field(48'(op), 2);
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'($urandom), 4);
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'(tpa), 4);
    set_length(len);
  endfunction

  function automatic void build_ipv4(input logic [7:0] ver_ihl, input logic [7:0] proto,
                                     input logic [IP_W-1:0] dst, input int len);
    frame_bytes.delete();
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'(ETH_IPV4), 2);
    frame_bytes.push_back(ver_ihl);
    // TOS, total length, id, flags and TTL
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'($urandom), 2);
    frame_bytes.push_back(proto);
    put_field(48'({$urandom, $urandom}), 6);
    put_field(48'(dst), 4);
    // UDP header: source port, then destination port, length and checksum
    put_field(48'($urandom), 4);
    put_field(48'($urandom), 4);
    set_length(len);
  endfunction

  // hold the request until the filter takes it; called and returns at a rising edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid     <= 1'b0;
      in_if.rx_byte   <= 8'($urandom);
      in_if.frame_end <= 1'($urandom);
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.rx_byte   <= b;
    in_if.frame_end <= last;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_frame();
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] mac, input logic [CFG_DATA_W-1:0] srv,
                              input logic [CFG_DATA_W-1:0] ip);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OUR_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_index <= REG_SERVER_MAC;
    cfg_wdata <= srv;
    @(posedge clk);
    cfg_index <= REG_OUR_IP;
    cfg_wdata <= ip;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_our_ip = ip[IP_W-1:0];
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input logic [CFG_DATA_W-1:0] mac, input logic [CFG_DATA_W-1:0] srv,
                           input logic [CFG_DATA_W-1:0] ip);
    int unsigned pick;
    write_config(mac, srv, ip);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (FRAMES_PER_PHASE) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: build_arp(ARP_OP_REQ, cur_our_ip, $urandom_range(42, 46));
        3, 4, 5: build_ipv4({IP_VER4, IHL_NO_OPTS}, IP_UDP, cur_our_ip, $urandom_range(42, 48));
        6: build_arp($urandom_range(0, 1) ? ARP_OP_REQ : 16'($urandom),
                     $urandom_range(0, 1) ? cur_our_ip : $urandom, $urandom_range(30, 46));
        7: build_ipv4(8'($urandom), $urandom_range(0, 1) ? IP_UDP : 8'($urandom),
                      $urandom_range(0, 1) ? cur_our_ip : $urandom, $urandom_range(30, 48));
        8: begin
          // good frame with one header byte broken
          if ($urandom_range(0, 1))
            build_arp(ARP_OP_REQ, cur_our_ip, $urandom_range(42, 46));
          else
            build_ipv4({IP_VER4, IHL_NO_OPTS}, IP_UDP, cur_our_ip, $urandom_range(42, 48));
          frame_bytes[$urandom_range(12, 41)] = 8'($urandom);
        end
        default: begin
          frame_bytes.delete();
          set_length($urandom_range(1, 40));
        end
      endcase
      send_frame();
    end
    wait_drained();
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_OUR_MAC;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    in_if.frame_end = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a write to the unused index must leave the reset addresses alone
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= CFG_DATA_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;

    build_arp(ARP_OP_REQ, cur_our_ip, 42);
    send_frame();
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    wait_drained();

    run_phase(0, 0, '1, '0, '1);
    run_phase(78, 0, '0, '1, '0);
    run_phase(0, 78, CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W'({$urandom, $urandom}),
              CFG_DATA_W'($urandom));
    run_phase(16, 16, CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W'({$urandom, $urandom}),
              CFG_DATA_W'($urandom));

    // stall the output for a long stretch while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    build_ipv4({IP_VER4, IHL_NO_OPTS}, IP_UDP, cur_our_ip, 50);
    frame_bytes[34] = 8'hFF;
    frame_bytes[35] = 8'hFF;
    send_frame();
    wait_drained();

    @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
